[src/lzzc_pkg.sv]
package lzzc_pkg;

    // Word and block geometry
    localparam int DATA_W  = 32;
    localparam int MAX_W   = 64;
    localparam int MAX_H   = 64;
    localparam int MAX_T   = 1024;
    localparam int PW_W    = $clog2(MAX_W);
    localparam int PH_W    = $clog2(MAX_H);
    localparam int PT_W    = $clog2(MAX_T);
    localparam int DW_W    = 7;
    localparam int DH_W    = 7;
    localparam int DT_W    = 11;
    localparam int CNT_W   = 6;
    localparam int TDATA_W = 40;

    // Plane memory holds one word per (row, column) of a plane
    localparam int P_DEPTH = MAX_H * MAX_W;
    localparam int PA_W    = PH_W + PW_W;

    // Configuration channel
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 11;
    localparam logic [CIDX_W-1:0] CFG_MODE  = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_DIM_T = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_DIM_H = 8'd2;
    localparam logic [CIDX_W-1:0] CFG_DIM_W = 8'd3;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Per-word control carried down the pipeline
    typedef struct packed {
        logic            vt;
        logic            vh;
        logic            vw;
        logic            last;
        logic [PH_W-1:0] h;
        logic [PW_W-1:0] w;
    } tag_t;

    function automatic logic [DATA_W-1:0] zz_enc(input logic [DATA_W-1:0] v);
        return {v[DATA_W-2:0], 1'b0} ^ {DATA_W{v[DATA_W-1]}};
    endfunction

    function automatic logic [DATA_W-1:0] zz_dec(input logic [DATA_W-1:0] z);
        return {1'b0, z[DATA_W-1:1]} ^ {DATA_W{z[0]}};
    endfunction

    // Position of the highest set bit plus one, at least one
    function automatic logic [CNT_W-1:0] bits_of(input logic [DATA_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = CNT_W'(1);
        for (int i = 1; i < DATA_W; i++) begin
            if (v[i]) begin
                n = CNT_W'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [DT_W-1:0] clamp_t(input logic [DT_W-1:0] v);
        if (v == '0) begin
            return DT_W'(1);
        end else if (v > DT_W'(MAX_T)) begin
            return DT_W'(MAX_T);
        end
        return v;
    endfunction

    function automatic logic [DH_W-1:0] clamp_h(input logic [DH_W-1:0] v);
        if (v == '0) begin
            return DH_W'(1);
        end else if (v > DH_W'(MAX_H)) begin
            return DH_W'(MAX_H);
        end
        return v;
    endfunction

    function automatic logic [DW_W-1:0] clamp_w(input logic [DW_W-1:0] v);
        if (v == '0) begin
            return DW_W'(1);
        end else if (v > DW_W'(MAX_W)) begin
            return DW_W'(MAX_W);
        end
        return v;
    endfunction

endpackage

[src/lorenzo3d_zigzag_codec.sv]
// A word accepted at the input moves through stages 1, 2 and 3 and then into
// the output register offered on m_tdata. Throughput: one word per cycle when
// dim_w is 3 or more and m_tready does not stall the output; narrower rows wait
// until the word above or in the previous plane is written back from stage 3.
// Reset (aresetn low, synchronous) empties the pipeline, restarts the block,
// selects encode and an 8x8x8 block; memory contents are not cleared.
module lorenzo3d_zigzag_codec
    import lzzc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // [31:0] data_in
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // [31:0] data_out, [37:32] bit_count, [39:38] zero
    output logic                m_tlast,   // block_last
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CDATA_W-1:0]  cfg_data
);

    // Configuration and position state
    logic             mode_reg, mode_next;
    logic [DT_W-1:0]  dim_t_reg, dim_t_next;
    logic [DH_W-1:0]  dim_h_reg, dim_h_next;
    logic [DW_W-1:0]  dim_w_reg, dim_w_next;
    logic [PT_W-1:0]  pos_t_reg, pos_t_next;
    logic [PH_W-1:0]  pos_h_reg, pos_h_next;
    logic [PW_W-1:0]  pos_w_reg, pos_w_next;
    logic [DATA_W-1:0] or_reg, or_next;

    // Pipeline valids
    logic p1_v_reg, p1_v_next;
    logic p2_v_reg, p2_v_next;
    logic p3_v_reg, p3_v_next;
    logic m_v_reg, m_v_next;

    // Pipeline payload
    tag_t              p1_tag_reg, p2_tag_reg, p3_tag_reg;
    logic [DATA_W-1:0] p1_x_reg, p2_x_reg, p3_x_reg;
    logic [DATA_W-1:0] rd_a_reg, p2_a_reg, p3_a_reg;
    logic [2*DATA_W-1:0] rd_r_reg;
    logic [DATA_W-1:0] p2_u_reg, p3_q_reg;
    logic [DATA_W-1:0] u_last_reg, code_last_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic [CNT_W-1:0]  m_cnt_reg;
    logic              m_last_reg;

    // Memories: previous plane by (row, column), and row above as {code, code a plane back}
    logic [DATA_W-1:0]   plane_mem [P_DEPTH];
    logic [2*DATA_W-1:0] row_mem   [MAX_W];

    // Handshake and hazard signals
    logic out_ready, p3_move, p3_rdy, p2_move, p2_rdy, p1_move, p1_rdy;
    logic accept, hazard, haz_p, haz_r;
    tag_t tag_n;
    logic [PA_W-1:0] rd_addr, p3_addr;

    // Datapath signals
    logic [DATA_W-1:0] ga, gb, gc, u1, ul, q2, cp, code3, zig3, acc3;

    // Stage advance, each stage moves when the next one is free or moving
    assign out_ready = !m_v_reg || m_tready;
    assign p3_move   = p3_v_reg && out_ready;
    assign p3_rdy    = !p3_v_reg || out_ready;
    assign p2_move   = p2_v_reg && p3_rdy;
    assign p2_rdy    = !p2_v_reg || p3_rdy;
    assign p1_move   = p1_v_reg && p2_rdy;
    assign p1_rdy    = !p1_v_reg || p2_rdy;

    // Neighbour validity and end of block for the word at the input
    always_comb begin
        tag_n.vt   = (pos_t_reg != '0);
        tag_n.vh   = (pos_h_reg != '0);
        tag_n.vw   = (pos_w_reg != '0);
        tag_n.last = ({1'b0, pos_t_reg} + DT_W'(1) >= dim_t_reg)
                  && ({1'b0, pos_h_reg} + DH_W'(1) >= dim_h_reg)
                  && ({1'b0, pos_w_reg} + DW_W'(1) >= dim_w_reg);
        tag_n.h    = pos_h_reg;
        tag_n.w    = pos_w_reg;
    end

    assign rd_addr = {pos_h_reg, pos_w_reg};
    assign p3_addr = {p3_tag_reg.h, p3_tag_reg.w};

    // Interlock while a word not yet written back owns an entry this word reads
    always_comb begin
        haz_p = tag_n.vt && (
                   (p1_v_reg && p1_tag_reg.h == pos_h_reg && p1_tag_reg.w == pos_w_reg)
                || (p2_v_reg && p2_tag_reg.h == pos_h_reg && p2_tag_reg.w == pos_w_reg)
                || (p3_v_reg && !p3_move && p3_addr == rd_addr));
        haz_r = tag_n.vh && (
                   (p1_v_reg && p1_tag_reg.w == pos_w_reg)
                || (p2_v_reg && p2_tag_reg.w == pos_w_reg)
                || (p3_v_reg && !p3_move && p3_tag_reg.w == pos_w_reg));
        hazard = haz_p || haz_r;
    end

    assign s_tready  = p1_rdy && !hazard;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Stage 1: plane-level partial sum of the current column
    always_comb begin
        ga = p1_tag_reg.vt ? rd_a_reg : '0;
        gc = p1_tag_reg.vh ? rd_r_reg[2*DATA_W-1:DATA_W] : '0;
        gb = (p1_tag_reg.vt && p1_tag_reg.vh) ? rd_r_reg[DATA_W-1:0] : '0;
        u1 = ga + gc - gb;
    end

    // Stage 2: fold in the previous column's partial sum
    always_comb begin
        ul = p2_tag_reg.vw ? u_last_reg : '0;
        if (mode_reg == MODE_DECODE) begin
            q2 = zz_dec(p2_x_reg) + p2_u_reg - ul;
        end else begin
            q2 = p2_x_reg - p2_u_reg + ul;
        end
    end

    // Stage 3: close the loop on the previous word's code
    always_comb begin
        cp = p3_tag_reg.vw ? code_last_reg : '0;
        if (mode_reg == MODE_DECODE) begin
            code3 = p3_q_reg + cp;
            zig3  = p3_x_reg;
        end else begin
            code3 = p3_x_reg;
            zig3  = zz_enc(p3_q_reg - cp);
        end
        acc3 = or_reg | zig3;
    end

    // Memory write-back and registered reads with same-edge bypass
    always_ff @(posedge aclk) begin
        if (p3_move) begin
            plane_mem[p3_addr] <= code3;
        end
        if (accept) begin
            if (p3_move && p3_addr == rd_addr) begin
                rd_a_reg <= code3;
            end else begin
                rd_a_reg <= plane_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p3_move) begin
            row_mem[p3_tag_reg.w] <= {code3, p3_a_reg};
        end
        if (accept) begin
            if (p3_move && p3_tag_reg.w == pos_w_reg) begin
                rd_r_reg <= {code3, p3_a_reg};
            end else begin
                rd_r_reg <= row_mem[pos_w_reg];
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_tag_reg <= tag_n;
            p1_x_reg   <= s_tdata;
        end
        if (p1_move) begin
            p2_tag_reg <= p1_tag_reg;
            p2_x_reg   <= p1_x_reg;
            p2_a_reg   <= rd_a_reg;
            p2_u_reg   <= u1;
        end
        if (p2_move) begin
            p3_tag_reg <= p2_tag_reg;
            p3_x_reg   <= p2_x_reg;
            p3_a_reg   <= p2_a_reg;
            p3_q_reg   <= q2;
            u_last_reg <= p2_u_reg;
        end
        if (p3_move) begin
            code_last_reg <= code3;
            m_data_reg    <= (mode_reg == MODE_DECODE) ? code3 : zig3;
            m_last_reg    <= p3_tag_reg.last;
            m_cnt_reg     <= p3_tag_reg.last ? bits_of(acc3) : '0;
        end
    end

    // Valids, position, running OR and configuration
    always_comb begin
        p1_v_next = accept  ? 1'b1 : (p1_move ? 1'b0 : p1_v_reg);
        p2_v_next = p1_move ? 1'b1 : (p2_move ? 1'b0 : p2_v_reg);
        p3_v_next = p2_move ? 1'b1 : (p3_move ? 1'b0 : p3_v_reg);
        m_v_next  = p3_move ? 1'b1 : (m_tready ? 1'b0 : m_v_reg);

        mode_next  = mode_reg;
        dim_t_next = dim_t_reg;
        dim_h_next = dim_h_reg;
        dim_w_next = dim_w_reg;
        pos_t_next = pos_t_reg;
        pos_h_next = pos_h_reg;
        pos_w_next = pos_w_reg;
        or_next    = or_reg;

        // Advance the raster position
        if (accept) begin
            if (tag_n.last) begin
                pos_t_next = '0;
                pos_h_next = '0;
                pos_w_next = '0;
            end else if ({1'b0, pos_w_reg} + DW_W'(1) < dim_w_reg) begin
                pos_w_next = pos_w_reg + PW_W'(1);
            end else begin
                pos_w_next = '0;
                if ({1'b0, pos_h_reg} + DH_W'(1) < dim_h_reg) begin
                    pos_h_next = pos_h_reg + PH_W'(1);
                end else begin
                    pos_h_next = '0;
                    pos_t_next = pos_t_reg + PT_W'(1);
                end
            end
        end

        // Accumulate the zigzag values of the block
        if (p3_move) begin
            or_next = p3_tag_reg.last ? '0 : acc3;
        end

        // A write to any of the four registers restarts the block
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MODE:  mode_next  = cfg_data[0];
                CFG_DIM_T: dim_t_next = clamp_t(cfg_data[DT_W-1:0]);
                CFG_DIM_H: dim_h_next = clamp_h(cfg_data[DH_W-1:0]);
                CFG_DIM_W: dim_w_next = clamp_w(cfg_data[DW_W-1:0]);
                default: ;
            endcase
            if (cfg_index == CFG_MODE || cfg_index == CFG_DIM_T
                || cfg_index == CFG_DIM_H || cfg_index == CFG_DIM_W) begin
                pos_t_next = '0;
                pos_h_next = '0;
                pos_w_next = '0;
                or_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            m_v_reg   <= 1'b0;
            mode_reg  <= MODE_ENCODE;
            dim_t_reg <= DT_W'(8);
            dim_h_reg <= DH_W'(8);
            dim_w_reg <= DW_W'(8);
            pos_t_reg <= '0;
            pos_h_reg <= '0;
            pos_w_reg <= '0;
            or_reg    <= '0;
        end else begin
            p1_v_reg  <= p1_v_next;
            p2_v_reg  <= p2_v_next;
            p3_v_reg  <= p3_v_next;
            m_v_reg   <= m_v_next;
            mode_reg  <= mode_next;
            dim_t_reg <= dim_t_next;
            dim_h_reg <= dim_h_next;
            dim_w_reg <= dim_w_next;
            pos_t_reg <= pos_t_next;
            pos_h_reg <= pos_h_next;
            pos_w_reg <= pos_w_next;
            or_reg    <= or_next;
        end
    end

    // Result channel
    assign m_tvalid = m_v_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(TDATA_W - DATA_W - CNT_W){1'b0}}, m_cnt_reg, m_data_reg};

endmodule

[src/lzzc_checker.sv]
module lzzc_checker
    import lzzc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Report a bit count on the last word of a block only
    a_cnt_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[37:32] == 6'd0)
        else $error("bit count on a word that does not end the block");

    a_cnt_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[37:32] != 6'd0 && m_tdata[37:32] <= 6'd32)
        else $error("bit count out of range on the last word");

    // Come out of reset with the result channel empty
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind lorenzo3d_zigzag_codec lzzc_checker u_lzzc_checker (.*);
